FILE: design/bptc_pkg.sv
// Types and constants shared by the barometric compensation pipeline.
// Depends on nothing; imported by baro_pressure_temperature_compensation.
package bptc_pkg;

  typedef struct packed {
    logic signed [23:0] raw_pressure;
    logic signed [23:0] raw_temperature;
  } bptc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic signed [39:0] pressure;
  } bptc_out_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // calibration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0_2   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_3_5   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_6_8   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_9_11  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_12_14 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_15_17 = 3'd5;

  // pressure accumulator width (pressure * 2^57 stays below 2^86)
  localparam int NW = 88;
  // half of the final divisor 25 * 2^51, for round-half-up
  localparam logic signed [NW-1:0] PRES_RND = NW'(25) <<< 50;

  localparam logic signed [31:0] TEMP_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] TEMP_MIN = 32'sh8000_0000;

  // floor division by 25: bias to non-negative, then reciprocal multiply
  localparam logic [16:0] DIV_D   = 17'd25;
  localparam logic [25:0] DIV_RCP = 26'd42949673;       // ceil(2^30 / 25)
  localparam logic [33:0] DIV_M   = 34'd1374389535;     // bias quotient
  localparam logic [36:0] DIV_OFS = 37'd34359738375;    // 25 * DIV_M

endpackage

FILE: design/baro_pressure_temperature_compensation.sv
// Barometric pressure/temperature polynomial compensation, eight-stage pipeline.
// Depends on bptc_pkg (payload structs, register indexes, rounding constants).
//
// Usage:
//  - cfg_we/cfg_index/cfg_wdata write the six 24-bit calibration registers
//    (first calibration byte in bits 23:16). Indexes above five are ignored.
//    Write only while the pipeline is empty.
//  - in_valid/in_stall/in_data carry one raw pressure and temperature pair;
//    a transfer happens on a clock edge with valid high and stall low.
//  - out_valid/out_stall/out_data return compensated temperature (1/65536 C)
//    and pressure (1/256 hPa), temperature saturating, one result per input, in order.
//  - Pipeline: an accepted input passes the eight register stages in order and
//    out_valid rises once it holds stage 8. One item per cycle is accepted while
//    in_stall is low; each of the eight register stages holds one multiply or a
//    short add chain and takes a new item every cycle it is free.
//  - Output stall: each stage advances on its own when the next one is free,
//    so bubbles collapse and input is still taken until the pipeline is full.
//    in_stall is low whenever out_stall is low.
//  - Reset (rst_n low, synchronous) empties the pipeline and clears all
//    calibration registers to zero.
module baro_pressure_temperature_compensation (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bptc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  bptc_pkg::bptc_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output bptc_pkg::bptc_out_t                   out_data
);
  import bptc_pkg::*;

  localparam int NST = 8;

  // ---------------- calibration registers ----------------
  logic [CFG_DATA_W-1:0] coef_r [0:5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEF_0_2:   coef_r[0] <= cfg_wdata;
        REG_COEF_3_5:   coef_r[1] <= cfg_wdata;
        REG_COEF_6_8:   coef_r[2] <= cfg_wdata;
        REG_COEF_9_11:  coef_r[3] <= cfg_wdata;
        REG_COEF_12_14: coef_r[4] <= cfg_wdata;
        REG_COEF_15_17: coef_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic signed [11:0] c0_w, c1_w;
  logic signed [19:0] c00_w, c10_w;
  logic signed [15:0] c01_w, c11_w, c20_w, c21_w, c30_w;

  assign c0_w  = $signed(coef_r[0][23:12]);
  assign c1_w  = $signed(coef_r[0][11:0]);
  assign c00_w = $signed(coef_r[1][23:4]);
  assign c10_w = $signed({coef_r[1][3:0], coef_r[2][23:8]});
  assign c01_w = $signed({coef_r[2][7:0], coef_r[3][23:16]});
  assign c11_w = $signed(coef_r[3][15:0]);
  assign c20_w = $signed(coef_r[4][23:8]);
  assign c21_w = $signed({coef_r[4][7:0], coef_r[5][23:16]});
  assign c30_w = $signed(coef_r[5][15:0]);

  // ---------------- pipeline control ----------------
  logic [NST:1] vld_r, vld_nxt;
  logic [NST:1] en_w;

  always_comb begin
    en_w[NST] = !vld_r[NST] || !out_stall;
    for (int s = NST - 1; s >= 1; s--) en_w[s] = !vld_r[s] || en_w[s+1];
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en_w[1]) vld_nxt[1] = in_valid;
    for (int s = 2; s <= NST; s++) begin
      if (en_w[s]) vld_nxt[s] = vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en_w[1];
  assign out_valid = vld_r[NST];

  // ---------------- stage 1: products of the raw samples ----------------
  logic signed [47:0] pp_w, tp_w;
  logic        [46:0] p2_1_r;
  logic signed [47:0] tp_1_r;
  logic signed [43:0] c10p_1_r;
  logic signed [39:0] c01t_1_r, c30p_1_r, c21t_1_r;
  logic signed [35:0] c1t_1_r;

  assign pp_w = in_data.raw_pressure * in_data.raw_pressure;
  assign tp_w = in_data.raw_temperature * in_data.raw_pressure;

  always_ff @(posedge clk) begin
    if (en_w[1]) begin
      p2_1_r   <= pp_w[46:0];            // square is never negative
      tp_1_r   <= tp_w;
      c10p_1_r <= c10_w * in_data.raw_pressure;
      c01t_1_r <= c01_w * in_data.raw_temperature;
      c30p_1_r <= c30_w * in_data.raw_pressure;
      c21t_1_r <= c21_w * in_data.raw_temperature;
      c1t_1_r  <= c1_w * in_data.raw_temperature;
    end
  end

  // ---------------- stage 2: first sums, second-order terms, temperature ----
  logic signed [36:0] tv_w, tr_w;
  logic signed [31:0] tsat_w;
  logic signed [44:0] x1_2_r;
  logic signed [40:0] y_2_r;
  logic signed [63:0] x2a_2_r, x2b_2_r;
  logic        [46:0] p2_2_r;
  logic signed [31:0] temp_r [2:NST-1];

  assign tv_w = (37'(c0_w) <<< 18) + 37'(c1t_1_r);
  assign tr_w = (tv_w + 37'sd4) >>> 3;

  always_comb begin
    if (tr_w[36:31] != {6{tr_w[36]}}) begin
      tsat_w = tr_w[36] ? TEMP_MIN : TEMP_MAX;
    end else begin
      tsat_w = tr_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_w[2]) begin
      x1_2_r    <= 45'(c10p_1_r) + 45'(c01t_1_r);
      y_2_r     <= 41'(c30p_1_r) + 41'(c21t_1_r);
      x2a_2_r   <= c20_w * $signed({1'b0, p2_1_r});
      x2b_2_r   <= c11_w * tp_1_r;
      p2_2_r    <= p2_1_r;
      temp_r[2] <= tsat_w;
    end
  end

  // ---------------- stage 3: cubic products split on p^2 ----------------
  logic signed [65:0]   yl_3_r;
  logic signed [64:0]   yh_3_r;
  logic signed [64:0]   x2_3_r;
  logic signed [NW-1:0] n0_3_r;

  always_ff @(posedge clk) begin
    if (en_w[3]) begin
      yl_3_r    <= y_2_r * $signed({1'b0, p2_2_r[23:0]});
      yh_3_r    <= y_2_r * $signed({1'b0, p2_2_r[46:24]});
      x2_3_r    <= 65'(x2a_2_r) + 65'(x2b_2_r);
      n0_3_r    <= (NW'(c00_w) <<< 57) + (NW'(x1_2_r) <<< 38);
      temp_r[3] <= temp_r[2];
    end
  end

  // ---------------- stage 4: partial sums of the scaled pressure ----------
  logic signed [NW-1:0] sa_4_r, sb_4_r;

  always_ff @(posedge clk) begin
    if (en_w[4]) begin
      sa_4_r    <= n0_3_r + (NW'(x2_3_r) <<< 19);
      sb_4_r    <= (NW'(yh_3_r) <<< 24) + NW'(yl_3_r) + PRES_RND;
      temp_r[4] <= temp_r[3];
    end
  end

  // ---------------- stage 5: full sum, drop 2^51 ----------------
  logic signed [NW-1:0] nsum_w;
  logic signed [36:0]   q_5_r;

  assign nsum_w = sa_4_r + sb_4_r;

  always_ff @(posedge clk) begin
    if (en_w[5]) begin
      q_5_r     <= nsum_w[NW-1:51];
      temp_r[5] <= temp_r[4];
    end
  end

  // ---------------- stage 6: bias, high quotient digit ----------------
  logic [36:0] u_w;
  logic [42:0] pa_w;
  logic [12:0] qa_6_r;
  logic [16:0] a_6_r;
  logic [19:0] b_6_r;

  assign u_w  = q_5_r + DIV_OFS;
  assign pa_w = 43'(u_w[36:20]) * 43'(DIV_RCP);

  always_ff @(posedge clk) begin
    if (en_w[6]) begin
      qa_6_r    <= pa_w[42:30];
      a_6_r     <= u_w[36:20];
      b_6_r     <= u_w[19:0];
      temp_r[6] <= temp_r[5];
    end
  end

  // ---------------- stage 7: remainder joins the low bits ----------------
  logic [16:0] ra_w;
  logic [24:0] rp_7_r;
  logic [12:0] qa_7_r;

  assign ra_w = a_6_r - 17'(qa_6_r) * DIV_D;

  always_ff @(posedge clk) begin
    if (en_w[7]) begin
      rp_7_r    <= {ra_w[4:0], b_6_r};
      qa_7_r    <= qa_6_r;
      temp_r[7] <= temp_r[6];
    end
  end

  // ---------------- stage 8: low quotient digit, unbias, output ----------
  logic [50:0]        pb_w;
  logic signed [33:0] pres_w;
  bptc_out_t          out_r;

  assign pb_w   = 51'(rp_7_r) * 51'(DIV_RCP);
  assign pres_w = $signed({1'b0, qa_7_r, pb_w[49:30]}) - $signed(DIV_M);

  always_ff @(posedge clk) begin
    if (en_w[8]) begin
      out_r.temperature <= temp_r[7];
      out_r.pressure    <= 40'(pres_w);
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  a_no_stall_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r == '0) |-> !in_stall)
    else $error("empty pipeline refuses input");

  a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[1])
    else $error("accepted input did not enter stage 1");

  a_stage1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[1] && !en_w[2]) |=> vld_r[1])
    else $error("blocked stage 1 item lost");
`endif

endmodule

FILE: bench/baro_comp_checker.sv
// Checker for the barometric compensation pipeline: tracks calibration writes,
// predicts each compensated reading and compares results in order.
// Depends on bptc_pkg for the payload structs and register indexes.
module baro_comp_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bptc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  bptc_pkg::bptc_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  bptc_pkg::bptc_out_t             out_data,
  output int                              errors,
  output int                              pending,
  output int                              checked
);
  import bptc_pkg::*;

  localparam logic signed [127:0] PRES_TOP  = (128'sd1 <<< 39) - 128'sd1;
  localparam logic signed [127:0] PRES_BOT  = -(128'sd1 <<< 39);
  // half of 25 * 2^51, the divisor that maps pressure * 2^57 to 1/256 hPa / 100
  localparam logic signed [128-1:0] PRES_HALF = 128'sd25 <<< 50;

  logic [CFG_DATA_W-1:0] coef_reg [6];
  bptc_out_t             expected_readings [$];
  int                    fail_cnt;
  int                    done_cnt;

  function automatic bptc_out_t compensate(input bptc_in_t raw);
    logic signed [127:0] c0, c1, c00, c10, c01, c11, c20, c21, c30;
    logic signed [127:0] p, t, tv, x1, p2, x2, y, acc, q, quo;
    bptc_out_t res;
    // unpack the eighteen calibration bytes into sign-extended coefficients
    c0  = $signed(coef_reg[0][23:12]);
    c1  = $signed(coef_reg[0][11:0]);
    c00 = $signed(coef_reg[1][23:4]);
    c10 = $signed({coef_reg[1][3:0], coef_reg[2][23:8]});
    c01 = $signed({coef_reg[2][7:0], coef_reg[3][23:16]});
    c11 = $signed(coef_reg[3][15:0]);
    c20 = $signed(coef_reg[4][23:8]);
    c21 = $signed({coef_reg[4][7:0], coef_reg[5][23:16]});
    c30 = $signed(coef_reg[5][15:0]);
    p   = $signed(raw.raw_pressure);
    t   = $signed(raw.raw_temperature);

    // T * 2^19 exact, then round half up to 2^-16 units
    tv = c0 * 128'sd262144 + c1 * t;
    tv = (tv + 128'sd4) >>> 3;
    if (tv > TEMP_MAX) res.temperature = TEMP_MAX;
    else if (tv < TEMP_MIN) res.temperature = TEMP_MIN;
    else res.temperature = tv[31:0];

    // P * 2^57 exact
    x1  = c10 * p + c01 * t;
    p2  = p * p;
    x2  = c20 * p2 + c11 * (t * p);
    y   = c30 * p + c21 * t;
    acc = (c00 <<< 57) + (x1 <<< 38) + (x2 <<< 19) + y * p2 + PRES_HALF;
    q   = acc >>> 51;
    quo = q / 128'sd25;
    if (q % 128'sd25 != 0 && q < 0) quo = quo - 128'sd1;
    if (quo > PRES_TOP) quo = PRES_TOP;
    else if (quo < PRES_BOT) quo = PRES_BOT;
    res.pressure = quo[39:0];
    return res;
  endfunction

  always @(posedge clk) begin
    bptc_out_t want;
    if (!rst_n) begin
      foreach (coef_reg[i]) coef_reg[i] = '0;
      expected_readings.delete();
      fail_cnt = 0;
      done_cnt = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          fail_cnt++;
          $display("%0t ERROR unexpected result transfer: expected none, got T=%0d P=%0d",
                   $time, out_data.temperature, out_data.pressure);
        end else begin
          want = expected_readings.pop_front();
          done_cnt++;
          if (out_data.temperature !== want.temperature) begin
            fail_cnt++;
            $display("%0t ERROR temperature: expected %0d, got %0d",
                     $time, want.temperature, out_data.temperature);
          end
          if (out_data.pressure !== want.pressure) begin
            fail_cnt++;
            $display("%0t ERROR pressure: expected %0d, got %0d",
                     $time, want.pressure, out_data.pressure);
          end
        end
      end
      if (in_valid && !in_stall) expected_readings.push_back(compensate(in_data));
      // spare indexes six and seven are dropped by the block
      if (cfg_we && cfg_index <= REG_COEF_15_17) coef_reg[cfg_index] = cfg_wdata;
    end
    errors  <= fail_cnt;
    pending <= expected_readings.size();
    checked <= done_cnt;
  end

endmodule

FILE: bench/baro_pressure_temperature_compensation_tb.sv
// Top of the compensation bench: clock, reset, calibration loads and raw sample stimulus.
// Depends on bptc_pkg, baro_pressure_temperature_compensation and baro_comp_checker.
module baro_pressure_temperature_compensation_tb;
  import bptc_pkg::*;

  typedef logic [0:5][CFG_DATA_W-1:0] coef_set_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] COEF_IDX [6] = '{REG_COEF_0_2, REG_COEF_3_5,
      REG_COEF_6_8, REG_COEF_9_11, REG_COEF_12_14, REG_COEF_15_17};

  localparam logic signed [23:0] RAW_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] RAW_MIN = 24'sh800000;

  // every coefficient at its positive / negative limit, all -1, and a rounding-tie set
  localparam coef_set_t COEF_POS_MAX = {24'h7FF7FF, 24'h7FFFF7, 24'hFFFF7F,
                                        24'hFF7FFF, 24'h7FFF7F, 24'hFF7FFF};
  localparam coef_set_t COEF_NEG_MAX = {24'h800800, 24'h800008, 24'h000080,
                                        24'h008000, 24'h800080, 24'h008000};
  localparam coef_set_t COEF_ONES    = {6{24'hFFFFFF}};
  // c1 = 1 and c10 = 25: t = +-4 and p = +-4096 land exactly on half units
  localparam coef_set_t COEF_TIE     = {24'h000001, 24'h000000, 24'h001900,
                                        24'h000000, 24'h000000, 24'h000000};

  localparam int LIMIT_TIME = 4_000_000;
  localparam int DRAIN_CYC  = 12;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  bptc_in_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  bptc_out_t             out_data;

  int errors;
  int pending;
  int checked;
  int send_idle;
  int recv_stall;
  int cal_sets;

  baro_pressure_temperature_compensation u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  baro_comp_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_coefs(input coef_set_t set);
    foreach (COEF_IDX[i]) write_reg(COEF_IDX[i], set[i]);
    cal_sets++;
  endtask

  // pipeline empty: drop valid, wait for every reading, then let the stages clear
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic send_pair(input logic signed [23:0] p, input logic signed [23:0] t);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{raw_pressure: p, raw_temperature: t};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [23:0] pick_raw();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return RAW_MAX;
          1: return RAW_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1: return 24'($signed($urandom_range(512)) - 256);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic coef_set_t random_coefs();
    coef_set_t set;
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(7))
        0: set[i] = '0;
        1: set[i] = '1;
        default: set[i] = 24'($urandom);
      endcase
    end
    return set;
  endfunction

  task automatic send_corners();
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(RAW_MIN, RAW_MIN);
    send_pair(RAW_MAX, RAW_MIN);
    send_pair(RAW_MIN, RAW_MAX);
    send_pair('0, '0);
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    send_idle  = 30;
    recv_stall = 69;
    cal_sets   = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // cleared calibration first
    send_pair(RAW_MAX, RAW_MIN);
    send_pair(24'sd1, -24'sd1);
    settle();

    // limit coefficients; extreme temperature drives saturate both ways
    load_coefs(COEF_POS_MAX);
    send_corners();
    settle();
    load_coefs(COEF_NEG_MAX);
    send_corners();
    settle();
    load_coefs(COEF_ONES);
    send_pair(-24'sd1, -24'sd1);
    send_pair(24'sd1, 24'sd1);
    send_pair(RAW_MAX, '0);
    settle();

    // half-unit ties; spare indexes must not disturb the set
    load_coefs(COEF_TIE);
    write_reg(REG_SPARE_6, 24'($urandom));
    write_reg(REG_SPARE_7, 24'hFFFFFF);
    send_pair(24'sd4096, 24'sd4);
    send_pair(-24'sd4096, -24'sd4);
    send_pair(24'sd12288, 24'sd12);
    send_pair(-24'sd12288, -24'sd12);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 30; recv_stall = 69; end
        1: begin send_idle = 69; recv_stall = 30; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int g = 0; g < 2; g++) begin
        settle();
        load_coefs(random_coefs());
        repeat (125) send_pair(pick_raw(), pick_raw());
      end
    end
    settle();

    $display("Summary: %0d compensated readings checked over %0d calibration sets,",
             checked, cal_sets);
    $display("  corner and tie samples, then random samples under three flow-control mixes");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(LIMIT_TIME);
    $display("Timeout with %0d readings outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
